// ----- hdl/ugfa_pkg.sv -----
package ugfa_pkg;

  localparam int CELL_COUNT_DEFAULT    = 1024;
  localparam int FRACTION_BITS_DEFAULT = 16;

  localparam int PROP_COUNT = 10;
  localparam int CELL_W     = 10;

  // property table codes, in load order
  localparam logic [3:0] P_WFLOW    = 4'd0;
  localparam logic [3:0] P_WFLOW_SL = 4'd1;
  localparam logic [3:0] P_GFLOW    = 4'd2;
  localparam logic [3:0] P_GFLOW_SL = 4'd3;
  localparam logic [3:0] P_MOB      = 4'd4;
  localparam logic [3:0] P_WMOB_SL  = 4'd5;
  localparam logic [3:0] P_GMOB_SL  = 4'd6;
  localparam logic [3:0] P_WDENS    = 4'd7;
  localparam logic [3:0] P_GDENS    = 4'd8;
  localparam logic [3:0] P_PERM     = 4'd9;

  // configuration register indexes
  localparam logic [1:0] CFG_STEP_SIZE = 2'd0;
  localparam logic [1:0] CFG_GRAVITY_X = 2'd1;
  localparam logic [1:0] CFG_GRAVITY_Y = 2'd2;
  localparam logic [1:0] CFG_GRAVITY_Z = 2'd3;

  localparam logic MODE_LOAD     = 1'b0;
  localparam logic MODE_ASSEMBLE = 1'b1;

  typedef struct packed {
    logic                      is_asm;
    logic                      left_ok;
    logic                      right_ok;
    logic [CELL_W-1:0]         left;
    logic [CELL_W-1:0]         right;
    logic [3:0]                prop;
    logic signed [31:0]        value;
    logic signed [31:0]        flux;
    logic signed [17:0]        nx;
    logic signed [17:0]        ny;
    logic signed [17:0]        nz;
  } item_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               clip;
  } sat_t;

  function automatic sat_t sat32(input logic signed [67:0] v);
    sat_t r;
    if (v > 68'sd2147483647) begin
      r.val  = 32'sh7fffffff;
      r.clip = 1'b1;
    end else if (v < -68'sd2147483648) begin
      r.val  = 32'sh80000000;
      r.clip = 1'b1;
    end else begin
      r.val  = v[31:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

endpackage

// ----- hdl/ugfa_ram.sv -----
module ugfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- hdl/ugfa_front.sv -----
module ugfa_front
  import ugfa_pkg::*;
#(
  parameter int CELL_COUNT = CELL_COUNT_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               mode,
  input  logic [CELL_W-1:0]  left_cell,
  input  logic [CELL_W-1:0]  right_cell,
  input  logic [3:0]         property_req,
  input  logic signed [31:0] value,
  input  logic signed [31:0] flux,
  input  logic signed [17:0] normal_x,
  input  logic signed [17:0] normal_y,
  input  logic signed [17:0] normal_z,
  output logic               q_valid,
  output item_t              q_item,
  input  logic               pop
);

  item_t      q [2];
  item_t      in_item;
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, keep;

  always_comb begin
    in_item.is_asm   = (mode == MODE_ASSEMBLE);
    in_item.left_ok  = 32'(left_cell) < 32'(CELL_COUNT);
    in_item.right_ok = 32'(right_cell) < 32'(CELL_COUNT);
    in_item.left     = left_cell;
    in_item.right    = right_cell;
    in_item.prop     = property_req;
    in_item.value    = value;
    in_item.flux     = flux;
    in_item.nx       = normal_x;
    in_item.ny       = normal_y;
    in_item.nz       = normal_z;
  end

  // loads of unknown tables or absent cells are dropped here
  assign keep    = in_item.is_asm ||
                   (32'(property_req) < 32'(PROP_COUNT) && in_item.left_ok);
  assign busy    = (count == 2'd2);
  assign push    = start && !busy && keep;
  assign q_valid = (count != 2'd0);
  assign q_item  = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- hdl/ugfa_back.sv -----
module ugfa_back
  import ugfa_pkg::*;
#(
  parameter int CELL_COUNT    = CELL_COUNT_DEFAULT,
  parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               pop,
  input  logic [30:0]        step_size,
  input  logic signed [31:0] gravity_x,
  input  logic signed [31:0] gravity_y,
  input  logic signed [31:0] gravity_z,
  output logic               done,
  output logic signed [31:0] residual_left,
  output logic signed [31:0] residual_right,
  output logic signed [31:0] jacobian_ll,
  output logic signed [31:0] jacobian_lr,
  output logic signed [31:0] jacobian_rl,
  output logic signed [31:0] jacobian_rr,
  output logic               saturated
);

  localparam int ADDR_W = $clog2(CELL_COUNT);
  localparam logic signed [67:0] HALF = 68'sd1 <<< (FRACTION_BITS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WRITE = 3'd1;
  localparam logic [2:0] ST_READL = 3'd2;
  localparam logic [2:0] ST_READR = 3'd3;
  localparam logic [2:0] ST_CAPR  = 3'd4;
  localparam logic [2:0] ST_CALC  = 3'd5;
  localparam logic [2:0] ST_FINAL = 3'd6;

  // sequencer steps: one product each
  localparam logic [4:0] S_FW_FLUX  = 5'd0;
  localparam logic [4:0] S_ADV      = 5'd1;
  localparam logic [4:0] S_DFW_FLUX = 5'd2;
  localparam logic [4:0] S_AU       = 5'd3;
  localparam logic [4:0] S_GN_X     = 5'd4;
  localparam logic [4:0] S_GN_Y     = 5'd5;
  localparam logic [4:0] S_GN_Z     = 5'd6;
  localparam logic [4:0] S_KGN      = 5'd7;
  localparam logic [4:0] S_FS       = 5'd8;
  localparam logic [4:0] S_DFL      = 5'd9;
  localparam logic [4:0] S_DFR      = 5'd10;
  localparam logic [4:0] S_X0       = 5'd11;
  localparam logic [4:0] S_XL_A     = 5'd12;
  localparam logic [4:0] S_XL_B     = 5'd13;
  localparam logic [4:0] S_XR_A     = 5'd14;
  localparam logic [4:0] S_XR_B     = 5'd15;
  localparam logic [4:0] S_U0       = 5'd16;
  localparam logic [4:0] S_V0L      = 5'd17;
  localparam logic [4:0] S_T0L      = 5'd18;
  localparam logic [4:0] S_V0R      = 5'd19;
  localparam logic [4:0] S_T0R      = 5'd20;
  localparam logic [4:0] S_UL       = 5'd21;
  localparam logic [4:0] S_VLL      = 5'd22;
  localparam logic [4:0] S_TLL      = 5'd23;
  localparam logic [4:0] S_VLR      = 5'd24;
  localparam logic [4:0] S_TLR      = 5'd25;
  localparam logic [4:0] S_UR       = 5'd26;
  localparam logic [4:0] S_VRL      = 5'd27;
  localparam logic [4:0] S_TRL      = 5'd28;
  localparam logic [4:0] S_VRR      = 5'd29;
  localparam logic [4:0] S_TRR      = 5'd30;

  logic [2:0]  state;
  logic [4:0]  step;
  logic        phase;
  item_t       cur;

  logic [31:0]        rdata [PROP_COUNT];
  logic [PROP_COUNT-1:0] we;
  logic [ADDR_W-1:0]  addr;
  logic signed [31:0] lv [PROP_COUNT];
  logic signed [31:0] rv [PROP_COUNT];

  logic signed [31:0] t, adv, au, gdn, kgn, fs, dfl, dfr, x0, xl, xr, u, v;
  logic signed [31:0] t0l, t0r, tll, tlr, trl, trr, dl, drl, drr;
  logic               gpos, clip;
  logic signed [65:0] prod;
  logic signed [66:0] acc;

  logic               flux_pos;
  logic signed [32:0] a, b, dt33;
  logic signed [66:0] sum;
  logic signed [67:0] rounded;
  sat_t               rw, xs, sdr_l, sdr_r, sdl;
  sat_t               f0, f1, f2, f3, f4, f5;
  logic signed [31:0] al, ar;

  assign pop  = (state == ST_IDLE) && q_valid;
  assign addr = (state == ST_READR) ? ADDR_W'(cur.right) : ADDR_W'(cur.left);

  for (genvar p = 0; p < PROP_COUNT; p++) begin : g_tab
    assign we[p] = (state == ST_WRITE) && (cur.prop == 4'(p));
    ugfa_ram #(.WIDTH(32), .DEPTH(CELL_COUNT)) u_ram (
      .clk   (clk),
      .we    (we[p]),
      .addr  (addr),
      .wdata (cur.value),
      .rdata (rdata[p])
    );
  end

  assign flux_pos = (cur.flux > 32'sd0);
  assign dt33     = $signed({2'b00, step_size});

  // operand select for the shared multiplier
  always_comb begin
    a = '0;
    b = '0;
    case (step)
      S_FW_FLUX:  begin a = 33'(flux_pos ? lv[P_WFLOW] : rv[P_WFLOW]); b = 33'(cur.flux); end
      S_ADV:      begin a = 33'(t); b = dt33; end
      S_DFW_FLUX: begin
        a = 33'(flux_pos ? lv[P_WFLOW_SL] : rv[P_WFLOW_SL]);
        b = 33'(cur.flux);
      end
      S_AU:       begin a = 33'(t); b = dt33; end
      S_GN_X:     begin a = 33'(cur.nx); b = 33'(gravity_x); end
      S_GN_Y:     begin a = 33'(cur.ny); b = 33'(gravity_y); end
      S_GN_Z:     begin a = 33'(cur.nz); b = 33'(gravity_z); end
      S_KGN:      begin a = 33'(lv[P_PERM]); b = 33'(gdn); end
      S_FS: begin
        a = 33'(gpos ? lv[P_WFLOW] : rv[P_WFLOW]);
        b = 33'(gpos ? rv[P_GFLOW] : lv[P_GFLOW]);
      end
      S_DFL: begin
        a = 33'(gpos ? lv[P_WFLOW_SL] : rv[P_WFLOW]);
        b = 33'(gpos ? rv[P_GFLOW] : lv[P_GFLOW_SL]);
      end
      S_DFR: begin
        a = 33'(gpos ? lv[P_WFLOW] : rv[P_WFLOW_SL]);
        b = 33'(gpos ? rv[P_GFLOW_SL] : lv[P_GFLOW]);
      end
      S_X0:   begin a = 33'(fs);  b = 33'(gpos ? lv[P_MOB] : rv[P_MOB]); end
      S_XL_A: begin a = 33'(dfl); b = 33'(gpos ? lv[P_MOB] : rv[P_MOB]); end
      S_XL_B: begin a = 33'(fs);  b = gpos ? 33'(dl) : '0; end
      S_XR_A: begin a = 33'(dfr); b = 33'(gpos ? lv[P_MOB] : rv[P_MOB]); end
      S_XR_B: begin a = 33'(fs);  b = gpos ? '0 : 33'(dl); end
      S_U0:   begin a = 33'(x0); b = 33'(kgn); end
      S_UL:   begin a = 33'(xl); b = 33'(kgn); end
      S_UR:   begin a = 33'(xr); b = 33'(kgn); end
      S_V0L, S_VLL, S_VRL: begin a = 33'(u); b = 33'(drl); end
      S_V0R, S_VLR, S_VRR: begin a = 33'(u); b = 33'(drr); end
      S_T0L, S_T0R, S_TLL, S_TLR, S_TRL, S_TRR: begin a = 33'(v); b = dt33; end
      default: ;
    endcase
  end

  // writeback: round to nearest (ties up), saturate
  always_comb begin
    sum     = ((step == S_GN_Y || step == S_GN_Z) ? acc : 67'sd0) + 67'(prod);
    rounded = (68'(sum) + HALF) >>> FRACTION_BITS;
    rw      = sat32(rounded);
    xs      = sat32(68'(t) + 68'(rw.val));
    sdr_l   = sat32(68'(lv[P_WDENS]) - 68'(lv[P_GDENS]));
    sdr_r   = sat32(68'(rv[P_WDENS]) - 68'(rv[P_GDENS]));
    sdl     = gpos ? sat32(68'(lv[P_WMOB_SL]) + 68'(lv[P_GMOB_SL]))
                   : sat32(68'(rv[P_WMOB_SL]) + 68'(rv[P_GMOB_SL]));
  end

  always_comb begin
    al = flux_pos ? au : 32'sd0;
    ar = flux_pos ? 32'sd0 : au;
    f0 = sat32(68'(adv) + 68'(t0l));
    f1 = sat32(-68'(adv) - 68'(t0r));
    f2 = sat32(68'(al) + 68'(tll));
    f3 = sat32(68'(ar) + 68'(trl));
    f4 = sat32(-68'(al) - 68'(tlr));
    f5 = sat32(-68'(ar) - 68'(trr));
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= q_item;
    if (state == ST_READR) begin
      for (int p = 0; p < PROP_COUNT; p++) begin
        lv[p] <= cur.left_ok ? $signed(rdata[p]) : 32'sd0;
      end
    end
    if (state == ST_CAPR) begin
      for (int p = 0; p < PROP_COUNT; p++) begin
        rv[p] <= cur.right_ok ? $signed(rdata[p]) : 32'sd0;
      end
    end
    if (state == ST_CALC && !phase) begin
      prod <= a * b;
    end
    if (state == ST_CALC && phase) begin
      acc <= sum;
      case (step)
        S_FW_FLUX, S_DFW_FLUX, S_XL_A, S_XR_A: t <= rw.val;
        S_ADV:  adv <= rw.val;
        S_AU:   au  <= rw.val;
        S_GN_Z: begin
          gdn  <= rw.val;
          gpos <= (rw.val > 32'sd0);
        end
        S_KGN:  kgn <= rw.val;
        S_FS:   fs  <= rw.val;
        S_DFL:  dfl <= rw.val;
        S_DFR:  dfr <= rw.val;
        S_X0:   x0  <= rw.val;
        S_XL_B: xl  <= xs.val;
        S_XR_B: xr  <= xs.val;
        S_U0, S_UL, S_UR: u <= rw.val;
        S_V0L, S_V0R, S_VLL, S_VLR, S_VRL, S_VRR: v <= rw.val;
        S_T0L:  t0l <= rw.val;
        S_T0R:  t0r <= rw.val;
        S_TLL:  tll <= rw.val;
        S_TLR:  tlr <= rw.val;
        S_TRL:  trl <= rw.val;
        S_TRR:  trr <= rw.val;
        default: ;
      endcase
      if (step == S_FW_FLUX) begin
        drl <= sdr_l.val;
        drr <= sdr_r.val;
      end
      if (step == S_KGN) dl <= sdl.val;
    end
    if (state == ST_FINAL) begin
      residual_left  <= f0.val;
      residual_right <= f1.val;
      jacobian_ll    <= f2.val;
      jacobian_lr    <= f3.val;
      jacobian_rl    <= f4.val;
      jacobian_rr    <= f5.val;
      saturated      <= clip | f0.clip | f1.clip | f2.clip | f3.clip | f4.clip | f5.clip;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      phase <= 1'b0;
      clip  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid) state <= q_item.is_asm ? ST_READL : ST_WRITE;
        end
        ST_WRITE: state <= ST_IDLE;
        ST_READL: state <= ST_READR;
        ST_READR: state <= ST_CAPR;
        ST_CAPR: begin
          state <= ST_CALC;
          step  <= S_FW_FLUX;
          phase <= 1'b0;
          clip  <= 1'b0;
        end
        ST_CALC: begin
          phase <= ~phase;
          if (phase) begin
            // partial g.n sums are not rounded values; only the full sum counts
            clip <= clip | (rw.clip & (step != S_GN_X) & (step != S_GN_Y))
                  | ((step == S_XL_B || step == S_XR_B) & xs.clip)
                  | ((step == S_FW_FLUX) & (sdr_l.clip | sdr_r.clip))
                  | ((step == S_KGN) & sdl.clip);
            if (step == S_TRR) begin
              state <= ST_FINAL;
            end else begin
              step <= step + 5'd1;
            end
          end
        end
        ST_FINAL: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/upwind_gravity_flux_assembly.sv -----
// Upwind gravity flux assembly. A load item (mode 0) writes one property of
// one cell and gives no result; an assemble item (mode 1) gives one result,
// shown on the result ports for exactly one cycle while done is high, which
// the receiver must take then. Items enter a two-entry queue; busy is high
// only while it is full. In the back end a load is one table write; an
// assemble does two reads of the single-port property tables, then 31
// products through one shared multiplier (each multiplied, then rounded and
// stored), then the final sums. Reading a property of a cell that was never
// loaded since reset gives undefined fields.
module upwind_gravity_flux_assembly
  import ugfa_pkg::*;
#(
  parameter int CELL_COUNT    = CELL_COUNT_DEFAULT,
  parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               mode,
  input  logic [CELL_W-1:0]  left_cell,
  input  logic [CELL_W-1:0]  right_cell,
  input  logic [3:0]         property_req,
  input  logic signed [31:0] value,
  input  logic signed [31:0] flux,
  input  logic signed [17:0] normal_x,
  input  logic signed [17:0] normal_y,
  input  logic signed [17:0] normal_z,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               done,
  output logic signed [31:0] residual_left,
  output logic signed [31:0] residual_right,
  output logic signed [31:0] jacobian_ll,
  output logic signed [31:0] jacobian_lr,
  output logic signed [31:0] jacobian_rl,
  output logic signed [31:0] jacobian_rr,
  output logic               saturated
);

  logic [30:0]        step_size;
  logic signed [31:0] gravity_x, gravity_y, gravity_z;
  logic               q_valid, pop;
  item_t              q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size <= 31'd65536;
      gravity_x <= 32'sd0;
      gravity_y <= 32'sd0;
      gravity_z <= -32'sd642253;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_STEP_SIZE: step_size <= cfg_data[30:0];
        CFG_GRAVITY_X: gravity_x <= $signed(cfg_data);
        CFG_GRAVITY_Y: gravity_y <= $signed(cfg_data);
        CFG_GRAVITY_Z: gravity_z <= $signed(cfg_data);
      endcase
    end
  end

  ugfa_front #(.CELL_COUNT(CELL_COUNT)) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .left_cell    (left_cell),
    .right_cell   (right_cell),
    .property_req (property_req),
    .value        (value),
    .flux         (flux),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .pop          (pop)
  );

  ugfa_back #(.CELL_COUNT(CELL_COUNT), .FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .pop            (pop),
    .step_size      (step_size),
    .gravity_x      (gravity_x),
    .gravity_y      (gravity_y),
    .gravity_z      (gravity_z),
    .done           (done),
    .residual_left  (residual_left),
    .residual_right (residual_right),
    .jacobian_ll    (jacobian_ll),
    .jacobian_lr    (jacobian_lr),
    .jacobian_rl    (jacobian_rl),
    .jacobian_rr    (jacobian_rr),
    .saturated      (saturated)
  );

endmodule
